// ----- rtl/imucd_pkg.sv -----
// Package: shared types, constants and register codes for the IMU crash detector.
package imucd_pkg;

	localparam int AvgDepth = 4;
	localparam int SlotW = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
	localparam int CntW = $clog2(AvgDepth + 1);
	localparam int SumW = 16 + CntW;

	typedef enum logic [2:0] {
		REG_ACCEL_TRIGGER = 3'd0,
		REG_ACCEL_SEVERE  = 3'd1,
		REG_ACCEL_MAX     = 3'd2,
		REG_GYRO_CONFIRM  = 3'd3,
		REG_GYRO_MEDIUM   = 3'd4,
		REG_GYRO_SEVERE   = 3'd5,
		REG_WINDOW_LENGTH = 3'd6,
		REG_DEBOUNCE_TIME = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQRT,
		ST_SUM,
		ST_DIV,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic sqrt_step;
		logic sum_step;
		logic div_start;
		logic div_step;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic sum_done;
		logic div_done;
		logic report;
	} status_t;

	typedef struct packed {
		logic [15:0] accel_trigger;
		logic [15:0] accel_severe;
		logic [15:0] accel_max;
		logic [15:0] gyro_confirm;
		logic [15:0] gyro_medium;
		logic [15:0] gyro_severe;
		logic [7:0]  window_length;
		logic [31:0] debounce_time;
	} cfg_t;

	function automatic logic [1:0] classify(input logic [15:0] a, input logic [15:0] g,
			input cfg_t c);
		logic [1:0] r;
		if (a > c.accel_max || g > c.gyro_severe) r = 2'd2;
		else if (a > c.accel_severe || g > c.gyro_medium) r = 2'd1;
		else r = 2'd0;
		return r;
	endfunction

endpackage

// ----- rtl/imucd_ctrl.sv -----
// Controller: sequences one sample through square, root, average, divide and decide.
module imucd_ctrl import imucd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_SQRT;
			ST_SQRT:   if (sts.sqrt_done) state_d = ST_SUM;
			ST_SUM:    if (sts.sum_done) state_d = ST_DIV;
			ST_DIV:    if (sts.div_done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT:    if (!sts.report || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT) && sts.report;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_SQUARE: begin
				cmd.square = 1'b1;
			end
			ST_SQRT:   cmd.sqrt_step = 1'b1;
			ST_SUM:    begin
				cmd.sum_step = 1'b1;
				cmd.div_start = sts.sum_done;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_OUT:    ;
			default:   ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SQUARE)
		else $error("load did not start sequence");

endmodule

// ----- rtl/imucd_dp.sv -----
// Datapath: magnitudes, moving average, window and debounce state, result register.
module imucd_dp import imucd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            sts,
	input  cfg_t               cfg,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic [31:0]        now_ms,
	output logic [1:0]         severity,
	output logic [15:0]        peak_accel_out,
	output logic [15:0]        peak_gyro_out,
	output logic               immediate
);

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [31:0] now_q;
	logic [31:0] arem_q, grem_q, aroot_q, groot_q, bit_q;
	logic [3:0] sq_cnt_q;
	logic [15:0] ahist_q [AvgDepth];
	logic [15:0] ghist_q [AvgDepth];
	logic [SlotW-1:0] slot_q;
	logic full_q;
	logic [CntW-1:0] count_q, sum_idx_q;
	logic [SumW-1:0] asum_q, gsum_q;
	logic [SumW-1:0] aquo_q, gquo_q, arm_q, grm_q;
	logic [4:0] div_cnt_q;
	logic win_q;
	logic [7:0] wsamp_q;
	logic [15:0] pa_q, pg_q;
	logic [31:0] last_q;
	logic seen_q;
	logic report_q;

	logic [31:0] sa, sg, at, gt;
	logic [SlotW-1:0] slot_nx;
	logic [CntW-1:0] cnt_nx;
	logic [15:0] a16, g16, npa, npg;
	logic [31:0] elapsed;
	logic [SumW-1:0] ar_sh, gr_sh;

	function automatic logic [31:0] sqr(input logic signed [15:0] v);
		logic signed [31:0] p;
		p = v * v;
		return 32'(p);
	endfunction

	assign sa = sqr(ax_q) + sqr(ay_q) + sqr(az_q);
	assign sg = sqr(gx_q) + sqr(gy_q) + sqr(gz_q);
	assign at = aroot_q + bit_q;
	assign gt = groot_q + bit_q;

	assign slot_nx = (slot_q == SlotW'(AvgDepth - 1)) ? '0 : slot_q + 1'b1;
	assign cnt_nx = (full_q || slot_nx == '0) ? CntW'(AvgDepth) : CntW'(slot_nx);

	assign ar_sh = {arm_q[SumW-2:0], asum_q[SumW-1]};
	assign gr_sh = {grm_q[SumW-2:0], gsum_q[SumW-1]};

	assign a16 = aquo_q[15:0];
	assign g16 = gquo_q[15:0];
	assign npa = (a16 > pa_q) ? a16 : pa_q;
	assign npg = (g16 > pg_q) ? g16 : pg_q;
	assign elapsed = now_q - last_q;

	assign sts.sqrt_done = (sq_cnt_q == 4'd15);
	assign sts.sum_done = (sum_idx_q == count_q - 1'b1);
	assign sts.div_done = (div_cnt_q == 5'(SumW - 1));
	assign sts.report = report_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= accel_x; ay_q <= accel_y; az_q <= accel_z;
			gx_q <= rate_x; gy_q <= rate_y; gz_q <= rate_z;
			now_q <= now_ms;
		end
		if (cmd.square) begin
			arem_q <= sa; grem_q <= sg;
			aroot_q <= '0; groot_q <= '0;
			bit_q <= 32'h4000_0000;
			sq_cnt_q <= '0;
		end
		if (cmd.sqrt_step) begin
			if (arem_q >= at) begin
				arem_q <= arem_q - at;
				aroot_q <= (aroot_q >> 1) + bit_q;
			end else aroot_q <= aroot_q >> 1;
			if (grem_q >= gt) begin
				grem_q <= grem_q - gt;
				groot_q <= (groot_q >> 1) + bit_q;
			end else groot_q <= groot_q >> 1;
			bit_q <= bit_q >> 2;
			sq_cnt_q <= sq_cnt_q + 1'b1;
			if (sts.sqrt_done) begin
				sum_idx_q <= '0;
				asum_q <= '0;
				gsum_q <= '0;
				count_q <= cnt_nx;
			end
		end
		if (cmd.sum_step) begin
			asum_q <= asum_q + SumW'(ahist_q[sum_idx_q[SlotW-1:0]]);
			gsum_q <= gsum_q + SumW'(ghist_q[sum_idx_q[SlotW-1:0]]);
			sum_idx_q <= sum_idx_q + 1'b1;
		end
		if (cmd.div_start) begin
			arm_q <= '0; grm_q <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			asum_q <= asum_q << 1;
			gsum_q <= gsum_q << 1;
			if (ar_sh >= SumW'(count_q)) begin
				arm_q <= ar_sh - SumW'(count_q);
				aquo_q <= {aquo_q[SumW-2:0], 1'b1};
			end else begin
				arm_q <= ar_sh;
				aquo_q <= {aquo_q[SumW-2:0], 1'b0};
			end
			if (gr_sh >= SumW'(count_q)) begin
				grm_q <= gr_sh - SumW'(count_q);
				gquo_q <= {gquo_q[SumW-2:0], 1'b1};
			end else begin
				grm_q <= gr_sh;
				gquo_q <= {gquo_q[SumW-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AvgDepth; i++) begin
				ahist_q[i] <= '0;
				ghist_q[i] <= '0;
			end
			slot_q <= '0; full_q <= 1'b0;
			win_q <= 1'b0; wsamp_q <= '0;
			pa_q <= '0; pg_q <= '0;
			last_q <= '0; seen_q <= 1'b0;
			report_q <= 1'b0;
			severity <= '0;
			peak_accel_out <= '0;
			peak_gyro_out <= '0;
			immediate <= 1'b0;
		end else begin
			if (cmd.sqrt_step && sts.sqrt_done) begin
				ahist_q[slot_q] <= 16'((aroot_q >> 1) + ((arem_q >= at) ? bit_q : 32'd0));
				ghist_q[slot_q] <= 16'((groot_q >> 1) + ((grem_q >= gt) ? bit_q : 32'd0));
				slot_q <= slot_nx;
				if (slot_nx == '0) full_q <= 1'b1;
			end
			if (cmd.decide) begin
				report_q <= 1'b0;
				if (!(seen_q && elapsed < cfg.debounce_time)) begin
					if (!win_q) begin
						if (a16 > cfg.accel_severe) begin
							report_q <= 1'b1;
							severity <= classify(a16, g16, cfg);
							peak_accel_out <= a16;
							peak_gyro_out <= g16;
							immediate <= 1'b1;
							last_q <= now_q; seen_q <= 1'b1;
						end else if (a16 > cfg.accel_trigger) begin
							win_q <= 1'b1; wsamp_q <= '0;
							pa_q <= a16; pg_q <= g16;
						end
					end else begin
						wsamp_q <= wsamp_q + 1'b1;
						pa_q <= npa; pg_q <= npg;
						if (npg > cfg.gyro_confirm && npa > cfg.accel_trigger) begin
							win_q <= 1'b0;
							report_q <= 1'b1;
							severity <= classify(npa, npg, cfg);
							peak_accel_out <= npa;
							peak_gyro_out <= npg;
							immediate <= 1'b0;
							last_q <= now_q; seen_q <= 1'b1;
						end else if (wsamp_q + 1'b1 >= cfg.window_length)
							win_q <= 1'b0;
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide && report_q |-> 1'b1 ##0 seen_q)
		else $error("report without timestamp");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide && win_q && !report_q |=> !(report_q && immediate) || !$past(win_q))
		else $error("immediate report with open window");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step && sts.sqrt_done |=> bit_q == 32'd0)
		else $error("root did not finish");

endmodule

// ----- rtl/imu_crash_detector_top.sv -----
// Top level: config registers, controller and datapath of the IMU crash detector.
// Usage:
// One input word is one IMU sample (six signed axes plus a ms timestamp), taken when
// in_valid is high and in_stall is low. in_stall is high while a sample is in work,
// so one sample is processed at a time.
// Each sample goes through accept, square, the shared two-lane bit-pair square
// root, a sum over the filled history (1 to 4 entries), the SumW-bit (19-bit)
// restoring divider, decide and output, in that order.
// A sample raises at most one result word on out_valid; the result is held,
// and no new sample taken, while out_stall is high.
// Config writes use cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high and writes are meant for idle periods. Out-of-range indexes are
// ignored.
// Reset clears history, window and debounce state and loads register defaults.
module imu_crash_detector_top import imucd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         severity,
	output logic [15:0]        peak_accel_out,
	output logic [15:0]        peak_gyro_out,
	output logic               immediate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_trigger <= 16'd10240;
			cfg_q.accel_severe <= 16'd16384;
			cfg_q.accel_max <= 16'd24576;
			cfg_q.gyro_confirm <= 16'd6560;
			cfg_q.gyro_medium <= 16'd9840;
			cfg_q.gyro_severe <= 16'd13120;
			cfg_q.window_length <= 8'd10;
			cfg_q.debounce_time <= 32'd3000;
		end else if (cfg_valid && !cfg_index[3]) begin
			unique case (reg_idx_t'(cfg_index[2:0]))
				REG_ACCEL_TRIGGER: cfg_q.accel_trigger <= cfg_data[15:0];
				REG_ACCEL_SEVERE:  cfg_q.accel_severe <= cfg_data[15:0];
				REG_ACCEL_MAX:     cfg_q.accel_max <= cfg_data[15:0];
				REG_GYRO_CONFIRM:  cfg_q.gyro_confirm <= cfg_data[15:0];
				REG_GYRO_MEDIUM:   cfg_q.gyro_medium <= cfg_data[15:0];
				REG_GYRO_SEVERE:   cfg_q.gyro_severe <= cfg_data[15:0];
				REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_data[7:0];
				REG_DEBOUNCE_TIME: cfg_q.debounce_time <= cfg_data;
				default: ;
			endcase
		end
	end

	imucd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	imucd_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg(cfg_q),
		.accel_x, .accel_y, .accel_z, .rate_x, .rate_y, .rate_z, .now_ms,
		.severity, .peak_accel_out, .peak_gyro_out, .immediate
	);

endmodule

// ----- test/tb_imu_crash_detector_top.sv -----
// Testbench for imu_crash_detector_top: directed table, then random streams vs a predictor.
module tb_imu_crash_detector_top import imucd_pkg::*; ();

	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [3:0] CFG_IDX_UNUSED = 4'd9;

	typedef struct packed {
		logic signed [15:0] ax, ay, az, gx, gy, gz;
		logic [31:0] t;
	} sample_t;

	typedef struct packed {
		logic [1:0]  sev;
		logic [15:0] pa;
		logic [15:0] pg;
		logic        imm;
	} report_t;

	typedef struct packed {
		sample_t s;
		logic    typed;
		logic    exp_hit;
		report_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] severity;
	logic [15:0] peak_accel_out, peak_gyro_out;
	logic immediate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	imu_crash_detector_top DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	cfg_t        m_cfg;
	logic [15:0] m_ahist [AvgDepth];
	logic [15:0] m_ghist [AvgDepth];
	int          m_slot;
	logic        m_full, m_win, m_seen;
	logic [7:0]  m_wcnt;
	logic [15:0] m_pa, m_pg;
	logic [31:0] m_last;

	report_t crash_q[$];
	int errors = 0;
	int tx_pct = 0, rx_pct = 0;
	int cycles = 0;
	logic [31:0] clock_ms = 0;

	function automatic logic [15:0] root_floor(input logic [31:0] v);
		logic [15:0] r, t;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if (32'(t) * 32'(t) <= v) r = t;
		end
		return r;
	endfunction

	function automatic logic [15:0] vec_mag(input logic signed [15:0] x, y, z);
		logic signed [31:0] xx, yy, zz;
		logic [31:0] s;
		xx = 32'(x);
		yy = 32'(y);
		zz = 32'(z);
		s = xx * xx + yy * yy + zz * zz;
		return root_floor(s);
	endfunction

	function automatic logic [1:0] crash_class(input logic [15:0] a, g);
		if (a > m_cfg.accel_max || g > m_cfg.gyro_severe) return 2'd2;
		if (a > m_cfg.accel_severe || g > m_cfg.gyro_medium) return 2'd1;
		return 2'd0;
	endfunction

	task automatic model_reset();
		m_cfg = '{16'd10240, 16'd16384, 16'd24576, 16'd6560, 16'd9840, 16'd13120,
			8'd10, 32'd3000};
		for (int i = 0; i < AvgDepth; i++) begin
			m_ahist[i] = '0;
			m_ghist[i] = '0;
		end
		m_slot = 0;
		m_full = 0;
		m_win = 0;
		m_wcnt = '0;
		m_pa = '0;
		m_pg = '0;
		m_last = '0;
		m_seen = 0;
	endtask

	task automatic predict_sample(input sample_t s, output logic hit, output report_t r);
		int cnt;
		logic [31:0] sa, sg;
		logic [15:0] a, g;
		hit = 0;
		r = '0;
		sa = 0;
		sg = 0;
		m_ahist[m_slot] = vec_mag(s.ax, s.ay, s.az);
		m_ghist[m_slot] = vec_mag(s.gx, s.gy, s.gz);
		m_slot = (m_slot + 1) % AvgDepth;
		if (m_slot == 0) m_full = 1;
		cnt = m_full ? AvgDepth : m_slot;
		if (cnt == 0) cnt = AvgDepth;
		for (int i = 0; i < cnt; i++) begin
			sa += 32'(m_ahist[i]);
			sg += 32'(m_ghist[i]);
		end
		a = 16'(sa / cnt);
		g = 16'(sg / cnt);
		if (m_seen && (s.t - m_last) < m_cfg.debounce_time) return;
		if (!m_win) begin
			if (a > m_cfg.accel_severe) begin
				hit = 1;
				r = '{crash_class(a, g), a, g, 1'b1};
			end else if (a > m_cfg.accel_trigger) begin
				m_win = 1;
				m_wcnt = '0;
				m_pa = a;
				m_pg = g;
			end
		end else begin
			m_wcnt = m_wcnt + 8'd1;
			if (a > m_pa) m_pa = a;
			if (g > m_pg) m_pg = g;
			if (m_pg > m_cfg.gyro_confirm && m_pa > m_cfg.accel_trigger) begin
				m_win = 0;
				hit = 1;
				r = '{crash_class(m_pa, m_pg), m_pa, m_pg, 1'b0};
			end else if (m_wcnt >= m_cfg.window_length) begin
				m_win = 0;
			end
		end
		if (hit) begin
			m_last = s.t;
			m_seen = 1;
			crash_q.push_back(r);
		end
	endtask

	// leaves cfg_valid high; caller lowers it after a batch
	task automatic reg_write(input logic [3:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		if (!idx[3]) begin
			case (reg_idx_t'(idx[2:0]))
				REG_ACCEL_TRIGGER: m_cfg.accel_trigger = d[15:0];
				REG_ACCEL_SEVERE:  m_cfg.accel_severe = d[15:0];
				REG_ACCEL_MAX:     m_cfg.accel_max = d[15:0];
				REG_GYRO_CONFIRM:  m_cfg.gyro_confirm = d[15:0];
				REG_GYRO_MEDIUM:   m_cfg.gyro_medium = d[15:0];
				REG_GYRO_SEVERE:   m_cfg.gyro_severe = d[15:0];
				REG_WINDOW_LENGTH: m_cfg.window_length = d[7:0];
				REG_DEBOUNCE_TIME: m_cfg.debounce_time = d;
				default: ;
			endcase
		end
	endtask

	task automatic send_sample(input sample_t s, output logic hit, output report_t r);
		if (($urandom % 100) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (($urandom % 100) < tx_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		{accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, now_ms} <= s;
		do @(posedge clk); while (in_stall);
		predict_sample(s, hit, r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (crash_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input int mode);
		logic [31:0] v;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: v = (i == 6) ? 32'd0 : 32'd0;
				1: v = 32'hFFFF_FFFF;
				default: begin
					if (i == 6) v = $urandom_range(1, 12);
					else if (i == 7) v = $urandom_range(0, 150);
					else v = $urandom_range(2000, 26000);
				end
			endcase
			reg_write(4'(i), v);
		end
		if (mode == 2) reg_write(CFG_IDX_UNUSED, $urandom);
		if (mode == 3) begin
			reg_write(4'(REG_WINDOW_LENGTH), 32'd255);
			reg_write(4'(REG_DEBOUNCE_TIME), 32'd3000);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		int kind, amp;
		kind = $urandom % 10;
		amp = (kind < 6) ? 3000 : $urandom_range(4000, 32767);
		s.ax = 16'($urandom_range(0, 2 * amp) - amp);
		s.ay = 16'($urandom_range(0, 2 * amp) - amp);
		s.az = 16'($urandom_range(0, 2 * amp) - amp);
		s.gx = 16'($urandom_range(0, 2 * amp) - amp);
		s.gy = 16'($urandom_range(0, 2 * amp) - amp);
		s.gz = 16'($urandom_range(0, 2 * amp) - amp);
		if (kind == 0) s = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom % 20)
			0:       clock_ms = $urandom;
			1:       clock_ms = clock_ms + $urandom_range(0, 5000);
			default: clock_ms = clock_ms + 5;
		endcase
		s.t = clock_ms;
		return s;
	endfunction

	dir_row_t dir_tab [14];

	always @(posedge clk) begin
		report_t e;
		if (out_valid && !out_stall) begin
			if (crash_q.size() == 0) begin
				errors++;
				$display("%0t unexpected report sev %0d pa %0d pg %0d imm %0d", $time,
					severity, peak_accel_out, peak_gyro_out, immediate);
			end else begin
				e = crash_q.pop_front();
				if (severity !== e.sev) begin
					errors++;
					$display("%0t severity exp %0d got %0d", $time, e.sev, severity);
				end
				if (peak_accel_out !== e.pa) begin
					errors++;
					$display("%0t accel peak exp %0d got %0d", $time, e.pa, peak_accel_out);
				end
				if (peak_gyro_out !== e.pg) begin
					errors++;
					$display("%0t gyro peak exp %0d got %0d", $time, e.pg, peak_gyro_out);
				end
				if (immediate !== e.imm) begin
					errors++;
					$display("%0t immediate exp %0d got %0d", $time, e.imm, immediate);
				end
			end
		end
		out_stall <= (($urandom % 100) < rx_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_imu_crash_detector_top: errors");
			$finish;
		end
	end

	initial begin
		logic hit;
		report_t r;
		dir_tab = '{
			'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0}, 1'b1, 1'b0, '0},
			'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
				-16'sd32768, 32'd5}, 1'b1, 1'b1, '{2'd2, 16'd28377, 16'd28377, 1'b1}},
			'{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
				32'd100}, 1'b0, 1'b0, '0},
			'{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 32'd3004}, 1'b0, 1'b0, '0},
			'{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 32'd3005}, 1'b0, 1'b0, '0},
			'{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 32'd3010}, 1'b0, 1'b0, '0},
			'{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 32'd3015}, 1'b0, 1'b0, '0},
			'{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 32'd3020}, 1'b0, 1'b0, '0},
			'{'{16'sd30000, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 32'd3025}, 1'b0, 1'b0, '0},
			'{'{16'sd20000, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 32'd3030}, 1'b0, 1'b0, '0},
			'{'{16'sd9000, 16'sd0, 16'sd0, 16'sd30000, 16'sd0, 16'sd0, 32'd3035}, 1'b0, 1'b0, '0},
			'{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFF0}, 1'b0,
				1'b0, '0},
			'{'{16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0005}, 1'b0, 1'b0, '0},
			'{'{16'sd0, -16'sd1, 16'sd1, -16'sd32768, 16'sd32767, 16'sd0, 32'hFFFF_FFFF}, 1'b0,
				1'b0, '0}
		};
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_sample(dir_tab[i].s, hit, r);
			if (dir_tab[i].typed && (hit !== dir_tab[i].exp_hit ||
					(hit && r !== dir_tab[i].exp))) begin
				errors++;
				$display("%0t row %0d exp %0d/%h got %0d/%h", $time, i, dir_tab[i].exp_hit,
					dir_tab[i].exp, hit, r);
			end
		end
		// window_length zero, all thresholds zero, then all-ones limits
		settle();
		set_regs(0);
		for (int i = 0; i < 20; i++) send_sample(rand_sample(), hit, r);
		settle();
		set_regs(1);
		for (int i = 0; i < 20; i++) send_sample(rand_sample(), hit, r);

		for (int ph = 0; ph < 3; ph++) begin
			tx_pct = (ph == 0) ? 9 : (ph == 1) ? 70 : 0;
			rx_pct = (ph == 0) ? 70 : (ph == 1) ? 9 : 0;
			for (int seg = 0; seg < 2; seg++) begin
				settle();
				set_regs((ph == 1 && seg == 1) ? 3 : 2);
				for (int i = 0; i < 265; i++) send_sample(rand_sample(), hit, r);
			end
		end

		settle();
		if (errors == 0) begin
			$display("tb_imu_crash_detector_top: clean");
		end else begin
			$display("tb_imu_crash_detector_top: errors");
		end
		$finish;
	end

endmodule
